### rtl/hmam_pkg.sv
// shared types and constants for the histogram mode / anti-mode unit
// no dependencies
package hmam_pkg;

	// fixed field widths of the result ports
	localparam int VALUE_W = 4;
	localparam int COUNT_W = 10;

	// per-cycle control from the sequencer to the scan unit
	typedef struct packed {
		logic init;   // start a new scan, forget previous extremes
		logic step;   // one bin count is presented this cycle
	} scan_ctl_t;

endpackage

### rtl/hmam_bin_mem.sv
// bin count memory: one write port, one registered read port
// depends on nothing
module hmam_bin_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/hmam_scan.sv
// scan unit: running maximum and minimum over non-empty bins
// depends on hmam_pkg
module hmam_scan import hmam_pkg::*; #(
	parameter int AW = 4,
	parameter int CW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  scan_ctl_t     ctl,
	input  logic [AW-1:0] idx,
	input  logic [CW-1:0] cnt,
	output logic [AW-1:0] hi_val,
	output logic [CW-1:0] hi_cnt,
	output logic [AW-1:0] lo_val,
	output logic [CW-1:0] lo_cnt,
	output logic          found
);

	logic [AW-1:0] hi_val_q, lo_val_q;
	logic [CW-1:0] hi_cnt_q, lo_cnt_q;
	logic          found_q;
	logic          take_hi, take_lo;

	// strict compares keep the lowest index on ties
	assign take_hi = !found_q || (cnt > hi_cnt_q);
	assign take_lo = !found_q || (cnt < lo_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.init) begin
			found_q <= 1'b0;
		end else if (ctl.step && (cnt != '0)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			hi_val_q <= '0;
			hi_cnt_q <= '0;
			lo_val_q <= '0;
			lo_cnt_q <= '0;
		end else if (ctl.step && (cnt != '0)) begin
			if (take_hi) begin
				hi_val_q <= idx;
				hi_cnt_q <= cnt;
			end
			if (take_lo) begin
				lo_val_q <= idx;
				lo_cnt_q <= cnt;
			end
		end
	end

	assign hi_val = hi_val_q;
	assign hi_cnt = hi_cnt_q;
	assign lo_val = lo_val_q;
	assign lo_cnt = lo_cnt_q;
	assign found  = found_q;

endmodule

### rtl/histogram_mode_antimode_unit.sv
// top level: histogram mode / anti-mode unit with its sequencer
// depends on hmam_pkg, hmam_bin_mem, hmam_scan
//
//   channel | ports                                     | transfer
//   --------+-------------------------------------------+------------------------
//   input   | value, last                               | start high, busy low
//   result  | most_value, most_count, least_value,      | done high, one cycle,
//           | least_count, any_present                  | cannot be held off
//
// an item without last is accepted, then its bin gets a read-modify-write
//   through the registered read port of the bin memory
// an item with last goes through the accept, the update, a scan pass
//   (one bin read per cycle, compared in the next cycle) and the result state
// reset: a clearing pass writes zero to every bin, busy high
// the scan zeroes each bin right after comparing it, so the next list starts
// from an empty histogram; the receiver cannot stall, done lasts one cycle
module histogram_mode_antimode_unit import hmam_pkg::*; #(
	parameter int NUM_BINS  = 16,
	parameter int COUNT_MAX = 1023
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [VALUE_W-1:0] value,
	input  logic               last,
	output logic               done,
	output logic [VALUE_W-1:0] most_value,
	output logic [COUNT_W-1:0] most_count,
	output logic [VALUE_W-1:0] least_value,
	output logic [COUNT_W-1:0] least_count,
	output logic               any_present
);

	localparam int AW = $clog2(NUM_BINS);
	localparam int CW = $clog2(COUNT_MAX + 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t        state_q;
	logic [AW:0]   idx_q;        // clear / scan address counter, reaches NUM_BINS
	logic [AW-1:0] addr_q;       // bin of the accepted item
	logic          in_range_q;   // accepted value selects a real bin
	logic          last_q;
	logic          pend_s1;      // read data of paddr_s1 arrives this cycle
	logic [AW-1:0] paddr_s1;

	logic          accept;
	logic          in_range;
	logic          scan_more;
	logic          scan_end;

	// memory ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [CW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [CW-1:0] mem_rdata;
	logic [CW-1:0] inc_cnt;

	// scan unit
	scan_ctl_t     scan_ctl;
	logic [AW-1:0] hi_val, lo_val;
	logic [CW-1:0] hi_cnt, lo_cnt;
	logic          found;

	assign accept   = start && (state_q == ST_IDLE);
	// values beyond the last bin are dropped, last still counts
	assign in_range = (32'(value) < NUM_BINS);

	assign scan_more = (idx_q < (AW+1)'(NUM_BINS));
	assign scan_end  = pend_s1 && (paddr_s1 == AW'(NUM_BINS - 1));

	// saturating increment of the bin that was just read
	assign inc_cnt = (mem_rdata == CW'(COUNT_MAX)) ? mem_rdata : mem_rdata + 1'b1;

	// read address: the incoming value while idle, the scan address otherwise
	assign mem_raddr = (state_q == ST_IDLE) ? AW'(value) : idx_q[AW-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_UPDATE: begin
				mem_we    = in_range_q;
				mem_waddr = addr_q;
				mem_wdata = inc_cnt;
			end
			ST_SCAN: begin
				// zero each bin once its count has been compared
				mem_we    = pend_s1;
				mem_waddr = paddr_s1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// scan control: clear the extremes when the last item's update is done
	assign scan_ctl.init = (state_q == ST_UPDATE) && last_q;
	assign scan_ctl.step = (state_q == ST_SCAN) && pend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == (AW+1)'(NUM_BINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					idx_q   <= '0;
					pend_s1 <= 1'b0;
					state_q <= last_q ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					pend_s1 <= scan_more;
					if (scan_more) begin
						idx_q <= idx_q + 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					pend_s1 <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload and scan pipeline address
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q     <= AW'(value);
			in_range_q <= in_range;
			last_q     <= last;
		end
		paddr_s1 <= idx_q[AW-1:0];
	end

	hmam_bin_mem #(
		.DEPTH (NUM_BINS),
		.AW    (AW),
		.DW    (CW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	hmam_scan #(
		.AW (AW),
		.CW (CW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.idx    (paddr_s1),
		.cnt    (mem_rdata),
		.hi_val (hi_val),
		.hi_cnt (hi_cnt),
		.lo_val (lo_val),
		.lo_cnt (lo_cnt),
		.found  (found)
	);

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	// extremes stay at zero when every bin was empty
	assign most_value  = VALUE_W'(hi_val);
	assign most_count  = COUNT_W'(hi_cnt);
	assign least_value = VALUE_W'(lo_val);
	assign least_count = COUNT_W'(lo_cnt);
	assign any_present = found;

endmodule

### sim/histogram_mode_antimode_unit_test.sv
// self-checking testbench for histogram_mode_antimode_unit: lists go in, per-list stats checked
// depends on hmam_pkg and the rtl of histogram_mode_antimode_unit
// a directed table runs first, then random lists; an in-bench histogram predicts each result not typed in by hand
module histogram_mode_antimode_unit_test import hmam_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BINS     = 16;
	localparam int COUNT_MAX    = 1023;
	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 500;
	localparam int IDLE_PERCENT = 23;
	// longest stretch without any transfer: clearing pass or a full scan plus sender gaps
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = NUM_BINS + 8;

	// one result of the block, field for field
	typedef struct packed {
		logic [VALUE_W-1:0] most_value;
		logic [COUNT_W-1:0] most_count;
		logic [VALUE_W-1:0] least_value;
		logic [COUNT_W-1:0] least_count;
		logic               any_present;
	} list_stats_t;

	// one row of the directed table: value repeated reps times, last only on the final one
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		int                 reps;
		bit                 typed;   // want holds the result read off by hand
		list_stats_t        want;
	} stim_row_t;

	localparam int NUM_ROWS = 20;
	localparam list_stats_t NO_STATS = '0;

	localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		// single element right after reset, lowest value
		'{4'd0,  1'b1, 1,    1'b1, '{4'd0,  10'd1,    4'd0,  10'd1,    1'b1}},
		// single element, highest value
		'{4'd15, 1'b1, 1,    1'b1, '{4'd15, 10'd1,    4'd15, 10'd1,    1'b1}},
		// distinct counts 3 / 2 / 1
		'{4'd8,  1'b0, 1,    1'b0, NO_STATS},
		'{4'd4,  1'b0, 1,    1'b0, NO_STATS},
		'{4'd8,  1'b0, 1,    1'b0, NO_STATS},
		'{4'd2,  1'b0, 1,    1'b0, NO_STATS},
		'{4'd4,  1'b0, 1,    1'b0, NO_STATS},
		'{4'd8,  1'b1, 1,    1'b0, NO_STATS},
		// tie between two bins, the lower value wins on both sides
		'{4'd6,  1'b0, 1,    1'b0, NO_STATS},
		'{4'd1,  1'b0, 1,    1'b0, NO_STATS},
		'{4'd6,  1'b0, 1,    1'b0, NO_STATS},
		'{4'd1,  1'b1, 1,    1'b1, '{4'd1,  10'd2,    4'd1,  10'd2,    1'b1}},
		// alternating bit patterns
		'{4'd10, 1'b0, 1,    1'b0, NO_STATS},
		'{4'd5,  1'b0, 2,    1'b0, NO_STATS},
		'{4'd10, 1'b1, 1,    1'b0, NO_STATS},
		// one bin driven past full scale stays saturated
		'{4'd9,  1'b0, 1030, 1'b0, NO_STATS},
		'{4'd9,  1'b1, 1,    1'b1, '{4'd9,  10'd1023, 4'd9,  10'd1023, 1'b1}},
		// saturated bin next to two single hits
		'{4'd12, 1'b0, 1100, 1'b0, NO_STATS},
		'{4'd3,  1'b0, 1,    1'b0, NO_STATS},
		'{4'd7,  1'b1, 1,    1'b0, NO_STATS}
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [VALUE_W-1:0] value;
	logic               last;
	logic               done;
	logic [VALUE_W-1:0] most_value;
	logic [COUNT_W-1:0] most_count;
	logic [VALUE_W-1:0] least_value;
	logic [COUNT_W-1:0] least_count;
	logic               any_present;

	// in-bench copy of the histogram and the results still to come
	logic [COUNT_W-1:0] tally [NUM_BINS];
	list_stats_t        pending_stats [$];
	int                 mismatches;
	int                 quiet_cycles;

	histogram_mode_antimode_unit #(
		.NUM_BINS  (NUM_BINS),
		.COUNT_MAX (COUNT_MAX)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.last        (last),
		.done        (done),
		.most_value  (most_value),
		.most_count  (most_count),
		.least_value (least_value),
		.least_count (least_count),
		.any_present (any_present)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// count one element; on the last one scan low to high, report and clear
	task automatic tally_value(input logic [VALUE_W-1:0] v, input logic l,
			output bit closes, output list_stats_t stats);
		bit found;
		found = 1'b0;
		stats = '0;
		closes = l;
		// a value beyond the bins is dropped, which a 4-bit field cannot reach with 16 bins
		if (int'(v) < NUM_BINS && int'(tally[v]) < COUNT_MAX)
			tally[v] = tally[v] + 1'b1;
		if (l) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				if (tally[i] != '0) begin
					if (!found) begin
						stats.most_value  = VALUE_W'(i);
						stats.most_count  = tally[i];
						stats.least_value = VALUE_W'(i);
						stats.least_count = tally[i];
						found = 1'b1;
					end else begin
						// strict compares keep the lowest value on a tie
						if (tally[i] > stats.most_count) begin
							stats.most_count = tally[i];
							stats.most_value = VALUE_W'(i);
						end
						if (tally[i] < stats.least_count) begin
							stats.least_count = tally[i];
							stats.least_value = VALUE_W'(i);
						end
					end
				end
			end
			stats.any_present = found;
			for (int i = 0; i < NUM_BINS; i++)
				tally[i] = '0;
		end
	endtask

	// hand one element to the block; returns once it is taken
	task automatic transfer_item(input logic [VALUE_W-1:0] v, input logic l, input bit may_idle,
			output bit closes, output list_stats_t stats);
		int gaps;
		gaps = 0;
		while (may_idle && $urandom_range(99) < IDLE_PERCENT)
			gaps++;
		repeat (gaps) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		last  <= l;
		// transfer happens at the first rising edge that sees busy low
		do
			@(posedge clk);
		while (busy);
		tally_value(v, l, closes, stats);
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// result checker: every strobe must match the oldest outstanding list
	always @(posedge clk) begin
		list_stats_t want;
		if (arst_n && done) begin
			if (pending_stats.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d/%0d %0d/%0d %0d",
					$time, most_value, most_count, least_value, least_count, any_present);
				mismatches++;
			end else begin
				want = pending_stats.pop_front();
				check_field("most_value",  want.most_value,  most_value);
				check_field("most_count",  want.most_count,  most_count);
				check_field("least_value", want.least_value, least_value);
				check_field("least_count", want.least_count, least_count);
				check_field("any_present", want.any_present, any_present);
			end
		end
	end

	// watchdog: too long without an input or a result transfer means the block hung
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		bit          closes;
		list_stats_t stats;
		int          sent;
		int          list_len;
		int          base;
		int          span;
		logic [VALUE_W-1:0] v;

		mismatches   = 0;
		quiet_cycles = 0;
		for (int i = 0; i < NUM_BINS; i++)
			tally[i] = '0;
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		last   = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed table; hand-typed rows replace the prediction, which still tracks state
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int k = 0; k < DIRECTED_ROWS[r].reps; k++) begin
				transfer_item(DIRECTED_ROWS[r].value,
					DIRECTED_ROWS[r].last && (k == DIRECTED_ROWS[r].reps - 1),
					DIRECTED_ROWS[r].reps < 8, closes, stats);
				if (closes)
					pending_stats.push_back(DIRECTED_ROWS[r].typed ? DIRECTED_ROWS[r].want : stats);
			end
		end

		// random lists: mostly short, some long; some drawn from a few neighboring
		// values so that repeats and ties are common
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			list_len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			span = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : NUM_BINS;
			base = $urandom_range(NUM_BINS - span);
			for (int k = 0; k < list_len; k++) begin
				v = VALUE_W'(base + $urandom_range(span - 1));
				// a long run of back-to-back transfers in the middle
				transfer_item(v, k == list_len - 1, !(sent >= 150 && sent < 300), closes, stats);
				if (closes)
					pending_stats.push_back(stats);
				sent++;
			end
		end

		@(negedge clk);
		start <= 1'b0;
		wait (pending_stats.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
